### design/rfpd_pkg.sv
`default_nettype none

package rfpd_pkg;

   localparam int unsigned PULSE_W   = 16;
   localparam int unsigned STAMP_W   = 32;
   localparam int unsigned CODE_W    = 24;
   localparam int unsigned MATCH_W   = 8;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DAT_W = 32;

   // Frame layout: 3 bytes of 8 bits, then a 4-bit guard for HT6P20
   localparam logic [2:0] BIT_LAST    = 3'd7;
   localparam logic [1:0] BYTE_LAST   = 2'd2;
   localparam logic [2:0] GUARD_LAST  = 3'd3;
   localparam logic [3:0] GUARD_MARK  = 4'd5;

   localparam logic KIND_EV1527 = 1'b0;
   localparam logic KIND_HT6P20 = 1'b1;

   // Reset values of the registers
   localparam logic [15:0] SYNC_MIN_RST        = 16'd6000;
   localparam logic [15:0] SYNC_MAX_RST        = 16'd16000;
   localparam logic [15:0] BIT_MIN_RST         = 16'd800;
   localparam logic [15:0] BIT_MAX_RST         = 16'd2000;
   localparam logic [7:0]  CONFIRM_COUNT_RST   = 8'd2;
   localparam logic [31:0] RELEASE_TIMEOUT_RST = 32'd200;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SYNC_MIN        = 3'd0,
      CSR_SYNC_MAX        = 3'd1,
      CSR_BIT_MIN         = 3'd2,
      CSR_BIT_MAX         = 3'd3,
      CSR_CONFIRM_COUNT   = 3'd4,
      CSR_RELEASE_TIMEOUT = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      EV_WAIT_SYNC = 2'd0,
      EV_DATA      = 2'd1,
      EV_CLOSE     = 2'd2
   } ev_phase_type;

   typedef enum logic [1:0] {
      HT_WAIT_PILOT = 2'd0,
      HT_DATA       = 2'd1,
      HT_GUARD      = 2'd2,
      HT_CLOSE      = 2'd3
   } ht_phase_type;

   typedef struct packed {
      logic [PULSE_W-1:0] sync_min;
      logic [PULSE_W-1:0] sync_max;
      logic [PULSE_W-1:0] bit_min;
      logic [PULSE_W-1:0] bit_max;
      logic [MATCH_W-1:0] confirm_count;
      logic [STAMP_W-1:0] release_timeout;
   } cfg_type;

   typedef struct packed {
      logic              valid;
      logic [CODE_W-1:0] code;
      logic              kind;
   } frame_type;

endpackage

`default_nettype wire

### design/rfpd_if.sv
`default_nettype none

interface rfpd_req_if;
   logic                         valid;
   logic                         ready;
   logic                         rising_edge;
   logic [rfpd_pkg::PULSE_W-1:0] pulse_time;
   logic [rfpd_pkg::STAMP_W-1:0] now;

   modport source (output valid, rising_edge, pulse_time, now, input ready);
   modport sink   (input valid, rising_edge, pulse_time, now, output ready);
endinterface

interface rfpd_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [rfpd_pkg::CODE_W-1:0] remote_code;
   logic                        remote_kind;

   modport source (output valid, remote_code, remote_kind, input ready);
   modport sink   (input valid, remote_code, remote_kind, output ready);
endinterface

`default_nettype wire

### design/rfpd_frame_dec.sv
`default_nettype none

module rfpd_frame_dec (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         fire,
   input  wire logic                         rising_edge,
   input  wire logic [rfpd_pkg::PULSE_W-1:0] pulse_time,
   input  wire rfpd_pkg::cfg_type            cfg,
   output rfpd_pkg::frame_type               frame
);

   logic [rfpd_pkg::PULSE_W-1:0] high_time_ff, high_time_in;
   logic [rfpd_pkg::PULSE_W-1:0] low_time_ff, low_time_in;
   logic [rfpd_pkg::PULSE_W:0]   period_sum;
   logic [rfpd_pkg::PULSE_W-1:0] period;
   logic                         sync_ok, bit_ok, high_wins, low_wins;
   logic                         ev_fire, ht_fire;

   rfpd_pkg::ev_phase_type      ev_phase_ff, ev_phase_in;
   logic [2:0]                  ev_bits_ff, ev_bits_in;
   logic [1:0]                  ev_bytes_ff, ev_bytes_in;
   logic [rfpd_pkg::CODE_W-1:0] ev_shift_ff, ev_shift_in;

   rfpd_pkg::ht_phase_type      ht_phase_ff, ht_phase_in;
   logic [2:0]                  ht_bits_ff, ht_bits_in;
   logic [1:0]                  ht_bytes_ff, ht_bytes_in;
   logic [rfpd_pkg::CODE_W-1:0] ht_shift_ff, ht_shift_in;
   logic [3:0]                  ht_guard_ff, ht_guard_in;

   assign ev_fire = fire && rising_edge;
   assign ht_fire = fire && !rising_edge;

   // Phase timing: a rising edge ends a low phase, a falling edge a high phase
   assign high_time_in = ht_fire ? pulse_time : high_time_ff;
   assign low_time_in  = ev_fire ? pulse_time : low_time_ff;
   assign period_sum   = {1'b0, high_time_in} + {1'b0, low_time_in};
   assign period       = period_sum[rfpd_pkg::PULSE_W-1:0];
   assign sync_ok      = (period >= cfg.sync_min) && (period <= cfg.sync_max);
   assign bit_ok       = (period >= cfg.bit_min) && (period <= cfg.bit_max);
   assign high_wins    = high_time_in > low_time_in;
   assign low_wins     = low_time_in > high_time_in;

   // EV1527 next phase
   always_comb begin
      ev_phase_in = ev_phase_ff;
      if (ev_fire) begin
         unique case (ev_phase_ff)
            rfpd_pkg::EV_WAIT_SYNC: begin
               if (sync_ok) ev_phase_in = rfpd_pkg::EV_DATA;
            end
            rfpd_pkg::EV_DATA: begin
               if (!bit_ok)
                  ev_phase_in = rfpd_pkg::EV_WAIT_SYNC;
               else if (ev_bits_ff == rfpd_pkg::BIT_LAST && ev_bytes_ff == rfpd_pkg::BYTE_LAST)
                  ev_phase_in = rfpd_pkg::EV_CLOSE;
            end
            rfpd_pkg::EV_CLOSE: begin
               ev_phase_in = sync_ok ? rfpd_pkg::EV_DATA : rfpd_pkg::EV_WAIT_SYNC;
            end
            default: ev_phase_in = rfpd_pkg::EV_WAIT_SYNC;
         endcase
      end
   end

   // HT6P20 next phase
   always_comb begin
      ht_phase_in = ht_phase_ff;
      if (ht_fire) begin
         unique case (ht_phase_ff)
            rfpd_pkg::HT_WAIT_PILOT: begin
               if (sync_ok) ht_phase_in = rfpd_pkg::HT_DATA;
            end
            rfpd_pkg::HT_DATA: begin
               if (!bit_ok)
                  ht_phase_in = rfpd_pkg::HT_WAIT_PILOT;
               else if (ht_bits_ff == rfpd_pkg::BIT_LAST && ht_bytes_ff == rfpd_pkg::BYTE_LAST)
                  ht_phase_in = rfpd_pkg::HT_GUARD;
            end
            rfpd_pkg::HT_GUARD: begin
               if (!bit_ok)
                  ht_phase_in = rfpd_pkg::HT_WAIT_PILOT;
               else if (ht_bits_ff == rfpd_pkg::GUARD_LAST)
                  ht_phase_in = ({ht_guard_ff[2:0], low_wins} == rfpd_pkg::GUARD_MARK) ?
                                rfpd_pkg::HT_CLOSE : rfpd_pkg::HT_WAIT_PILOT;
            end
            rfpd_pkg::HT_CLOSE: begin
               ht_phase_in = sync_ok ? rfpd_pkg::HT_DATA : rfpd_pkg::HT_WAIT_PILOT;
            end
            default: ht_phase_in = rfpd_pkg::HT_WAIT_PILOT;
         endcase
      end
   end

   // Shift registers, counters and frame output
   always_comb begin
      ev_bits_in  = ev_bits_ff;
      ev_bytes_in = ev_bytes_ff;
      ev_shift_in = ev_shift_ff;
      ht_bits_in  = ht_bits_ff;
      ht_bytes_in = ht_bytes_ff;
      ht_shift_in = ht_shift_ff;
      ht_guard_in = ht_guard_ff;
      frame       = '{valid: 1'b0, code: '0, kind: rfpd_pkg::KIND_EV1527};

      if (ev_fire) begin
         unique case (ev_phase_ff)
            rfpd_pkg::EV_WAIT_SYNC: begin
               if (sync_ok) begin
                  ev_bits_in  = '0;
                  ev_bytes_in = '0;
                  ev_shift_in = '0;
               end
            end
            rfpd_pkg::EV_DATA: begin
               if (bit_ok) begin
                  ev_shift_in = {ev_shift_ff[rfpd_pkg::CODE_W-2:0], high_wins};
                  ev_bits_in  = ev_bits_ff + 3'd1;
                  if (ev_bits_ff == rfpd_pkg::BIT_LAST) ev_bytes_in = ev_bytes_ff + 2'd1;
               end
            end
            default: begin
               if (sync_ok) begin
                  frame       = '{valid: 1'b1, code: ev_shift_ff, kind: rfpd_pkg::KIND_EV1527};
                  ev_bits_in  = '0;
                  ev_bytes_in = '0;
                  ev_shift_in = '0;
               end
            end
         endcase
      end

      if (ht_fire) begin
         unique case (ht_phase_ff)
            rfpd_pkg::HT_WAIT_PILOT: begin
               if (sync_ok) begin
                  ht_bits_in  = '0;
                  ht_bytes_in = '0;
                  ht_shift_in = '0;
                  ht_guard_in = '0;
               end
            end
            rfpd_pkg::HT_DATA: begin
               if (bit_ok) begin
                  ht_shift_in = {ht_shift_ff[rfpd_pkg::CODE_W-2:0], low_wins};
                  ht_bits_in  = ht_bits_ff + 3'd1;
                  if (ht_bits_ff == rfpd_pkg::BIT_LAST) ht_bytes_in = ht_bytes_ff + 2'd1;
               end
            end
            rfpd_pkg::HT_GUARD: begin
               if (bit_ok) begin
                  ht_guard_in = {ht_guard_ff[2:0], low_wins};
                  ht_bits_in  = ht_bits_ff + 3'd1;
               end
            end
            rfpd_pkg::HT_CLOSE: begin
               if (sync_ok) begin
                  frame       = '{valid: 1'b1, code: ht_shift_ff, kind: rfpd_pkg::KIND_HT6P20};
                  ht_bits_in  = '0;
                  ht_bytes_in = '0;
                  ht_shift_in = '0;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         high_time_ff <= '0;
         low_time_ff  <= '0;
         ev_phase_ff  <= rfpd_pkg::EV_WAIT_SYNC;
         ev_bits_ff   <= '0;
         ev_bytes_ff  <= '0;
         ev_shift_ff  <= '0;
         ht_phase_ff  <= rfpd_pkg::HT_WAIT_PILOT;
         ht_bits_ff   <= '0;
         ht_bytes_ff  <= '0;
         ht_shift_ff  <= '0;
         ht_guard_ff  <= '0;
      end else begin
         high_time_ff <= high_time_in;
         low_time_ff  <= low_time_in;
         ev_phase_ff  <= ev_phase_in;
         ev_bits_ff   <= ev_bits_in;
         ev_bytes_ff  <= ev_bytes_in;
         ev_shift_ff  <= ev_shift_in;
         ht_phase_ff  <= ht_phase_in;
         ht_bits_ff   <= ht_bits_in;
         ht_bytes_ff  <= ht_bytes_in;
         ht_shift_ff  <= ht_shift_in;
         ht_guard_ff  <= ht_guard_in;
      end
   end

endmodule

`default_nettype wire

### design/rfpd_confirm.sv
`default_nettype none

module rfpd_confirm (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire rfpd_pkg::frame_type          frame,
   input  wire logic [rfpd_pkg::STAMP_W-1:0] now,
   input  wire rfpd_pkg::cfg_type            cfg,
   output rfpd_pkg::frame_type               report
);

   logic [rfpd_pkg::CODE_W-1:0]  held_code_ff, held_code_in;
   logic                         held_kind_ff, held_kind_in;
   logic [rfpd_pkg::MATCH_W-1:0] match_count_ff, match_count_in;
   logic [rfpd_pkg::STAMP_W-1:0] deadline_ff, deadline_in;
   logic [rfpd_pkg::STAMP_W:0]   deadline_sum;
   logic [rfpd_pkg::STAMP_W-1:0] deadline_new;
   logic                         same_code, extended;

   assign deadline_sum = {1'b0, now} + {1'b0, cfg.release_timeout};
   assign deadline_new = deadline_sum[rfpd_pkg::STAMP_W-1:0];
   assign same_code    = (frame.kind == held_kind_ff) && (frame.code == held_code_ff);

   always_comb begin
      held_code_in   = held_code_ff;
      held_kind_in   = held_kind_ff;
      match_count_in = match_count_ff;
      deadline_in    = deadline_ff;
      extended       = 1'b0;
      report         = '{valid: 1'b0, code: frame.code, kind: frame.kind};

      if (frame.valid) begin
         held_code_in = frame.code;
         held_kind_in = frame.kind;
         if (!same_code) begin
            match_count_in = '0;
            deadline_in    = '0;
         end else if (deadline_ff != '0) begin
            if (now < deadline_ff) begin
               // still held: push the release time out, no report
               deadline_in = deadline_new;
               extended    = 1'b1;
            end else begin
               deadline_in    = '0;
               match_count_in = '0;
            end
         end else begin
            match_count_in = match_count_ff + 8'd1;
         end

         if (!extended && match_count_in >= cfg.confirm_count) begin
            report.valid   = 1'b1;
            deadline_in    = deadline_new;
            match_count_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_code_ff   <= '0;
         held_kind_ff   <= rfpd_pkg::KIND_EV1527;
         match_count_ff <= '0;
         deadline_ff    <= '0;
      end else begin
         held_code_ff   <= held_code_in;
         held_kind_ff   <= held_kind_in;
         match_count_ff <= match_count_in;
         deadline_ff    <= deadline_in;
      end
   end

endmodule

`default_nettype wire

### design/rf_remote_pulse_decoder_top.sv
// Flow: a transfer on req is held in the input stage and decoded when that stage fires, and a
//   code that it completes is registered in the result stage that drives rsp.
// Throughput: one edge item per cycle; a stalled rsp holds one item in the input stage.
// Reset (synchronous, active high): clears both frame decoders, the confirmer and the
//   handshake flags, and loads the register defaults; no clearing pass is needed.
`default_nettype none

module rf_remote_pulse_decoder_top (
   input  wire logic                           clock,
   input  wire logic                           reset,
   rfpd_req_if.sink                            req_ch,
   rfpd_rsp_if.source                          rsp_ch,
   input  wire logic                           csr_we,
   input  wire logic [rfpd_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [rfpd_pkg::CSR_DAT_W-1:0] csr_wdata
);

   // Configuration registers
   rfpd_pkg::cfg_type cfg_ff, cfg_in;

   // Input stage: one edge item waiting to be decoded
   logic                         in_valid_ff, in_valid_in;
   logic                         in_rising_ff;
   logic [rfpd_pkg::PULSE_W-1:0] in_pulse_ff;
   logic [rfpd_pkg::STAMP_W-1:0] in_now_ff;

   // Result stage
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [rfpd_pkg::CODE_W-1:0] rsp_code_ff;
   logic                        rsp_kind_ff;

   logic                advance, fire, take_req;
   rfpd_pkg::frame_type frame, report;

   // Advance the pipe whenever the result register is free or being emptied.
   assign advance  = !rsp_valid_ff || rsp_ch.ready;
   assign fire     = in_valid_ff && advance;
   assign take_req = !in_valid_ff || advance;

   assign req_ch.ready       = take_req;
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.remote_code = rsp_code_ff;
   assign rsp_ch.remote_kind = rsp_kind_ff;

   // Register writes: upper data bits drop for narrow registers, unknown indices do nothing
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            rfpd_pkg::CSR_SYNC_MIN:        cfg_in.sync_min        = csr_wdata[15:0];
            rfpd_pkg::CSR_SYNC_MAX:        cfg_in.sync_max        = csr_wdata[15:0];
            rfpd_pkg::CSR_BIT_MIN:         cfg_in.bit_min         = csr_wdata[15:0];
            rfpd_pkg::CSR_BIT_MAX:         cfg_in.bit_max         = csr_wdata[15:0];
            rfpd_pkg::CSR_CONFIRM_COUNT:   cfg_in.confirm_count   = csr_wdata[7:0];
            rfpd_pkg::CSR_RELEASE_TIMEOUT: cfg_in.release_timeout = csr_wdata;
            default: ;
         endcase
      end
   end

   // Hold the input stage while the result side stalls; refill on each transfer.
   assign in_valid_in  = take_req ? req_ch.valid : in_valid_ff;
   // Load a result only when the confirmer reports; drop the flag when it is taken.
   assign rsp_valid_in = advance ? report.valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '{sync_min:        rfpd_pkg::SYNC_MIN_RST,
                           sync_max:        rfpd_pkg::SYNC_MAX_RST,
                           bit_min:         rfpd_pkg::BIT_MIN_RST,
                           bit_max:         rfpd_pkg::BIT_MAX_RST,
                           confirm_count:   rfpd_pkg::CONFIRM_COUNT_RST,
                           release_timeout: rfpd_pkg::RELEASE_TIMEOUT_RST};
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_req && req_ch.valid) begin
         in_rising_ff <= req_ch.rising_edge;
         in_pulse_ff  <= req_ch.pulse_time;
         in_now_ff    <= req_ch.now;
      end
      if (advance && report.valid) begin
         rsp_code_ff <= report.code;
         rsp_kind_ff <= report.kind;
      end
   end

   // Edge timing and the two frame decoders
   rfpd_frame_dec u_frame_dec (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .rising_edge (in_rising_ff),
      .pulse_time  (in_pulse_ff),
      .cfg         (cfg_ff),
      .frame       (frame)
   );

   // Repeat matching and release hold
   rfpd_confirm u_confirm (
      .clock  (clock),
      .reset  (reset),
      .frame  (frame),
      .now    (in_now_ff),
      .cfg    (cfg_ff),
      .report (report)
   );

endmodule

`default_nettype wire

### design/rfpd_checker.sv
`default_nettype none

module rfpd_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready
);

   // A waiting result stays until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped before transfer");

   // An empty result register never blocks the input side.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with no result pending");

   // A fresh result comes from an item taken earlier through the input stage.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result without a matching input transfer");

   // Reset leaves no result pending.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

endmodule

bind rf_remote_pulse_decoder_top rfpd_checker u_rfpd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready)
);

`default_nettype wire
